FILE: sv/pdrg_pkg.sv
// Shared types and function codes for the per-device replay guard.
// No dependencies; imported by per_device_replay_guard_core.
package pdrg_pkg;

   localparam int DEVICE_ID_W = 8;
   localparam int COUNTER_W   = 64;
   localparam int FUNC_W      = 3;

   localparam logic [FUNC_W-1:0] FUNC_CHECK_DOWN  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_COMMIT_DOWN = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_ACCEPT_UP   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_RESET_DEV   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR_ALL   = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_PEEK_UP     = 3'd5;

   typedef struct packed {
      logic [FUNC_W-1:0]      func;
      logic [DEVICE_ID_W-1:0] device_id;
      logic [COUNTER_W-1:0]   counter;
   } req_type;

   typedef struct packed {
      logic                 ok;
      logic                 found;
      logic [COUNTER_W-1:0] last_counter;
   } rsp_type;

endpackage

FILE: sv/per_device_replay_guard_core.sv
// The request is registered in the first stage; its response is registered when that stage advances.
// One transaction per cycle while responses are taken, also for the same device back to back
// (the counter read of the next transaction bypasses the write of the current one).
// Reset (synchronous): clears every valid bit and the pipeline; the counter stores
// are not cleared and are read only behind a set valid bit.
// Depends on pdrg_pkg.
module per_device_replay_guard_core
   import pdrg_pkg::*;
#(
   parameter int DEVICE_COUNT = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int ID_SPAN = 1 << DEVICE_ID_W;
   localparam int DEPTH   = (DEVICE_COUNT < ID_SPAN) ? DEVICE_COUNT : ID_SPAN;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int ENTRIES = 1 << IDX_W;
   localparam int CMP_W   = 18;

   logic                 s1_valid_ff, s1_valid_in;
   req_type              s1_req_ff;
   logic [COUNTER_W-1:0] up_rd_ff, down_rd_ff;
   logic [COUNTER_W-1:0] up_last_mem   [ENTRIES];
   logic [COUNTER_W-1:0] down_last_mem [ENTRIES];
   logic [ENTRIES-1:0]   up_valid_ff, up_valid_in;
   logic [ENTRIES-1:0]   down_valid_ff, down_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic             req_accept;
   logic             advance;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] s1_idx;
   logic             in_range;
   logic             up_set, down_set;
   logic             up_we, down_we;

   assign rd_idx     = req_payload.device_id[IDX_W-1:0];
   assign s1_idx     = s1_req_ff.device_id[IDX_W-1:0];
   assign in_range   = CMP_W'(s1_req_ff.device_id) < CMP_W'(DEVICE_COUNT);
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   assign up_set = up_valid_ff[s1_idx];
   assign down_set = down_valid_ff[s1_idx];

   always_comb begin
      rsp_in        = '0;
      up_valid_in   = up_valid_ff;
      down_valid_in = down_valid_ff;
      up_we         = 1'b0;
      down_we       = 1'b0;
      if (s1_req_ff.func == FUNC_CLEAR_ALL) begin
         up_valid_in   = '0;
         down_valid_in = '0;
         rsp_in.ok     = 1'b1;
      end else if (in_range) begin
         case (s1_req_ff.func)
            FUNC_CHECK_DOWN: begin
               rsp_in.ok = !down_set || (s1_req_ff.counter > down_rd_ff);
            end
            FUNC_COMMIT_DOWN: begin
               down_we               = 1'b1;
               down_valid_in[s1_idx] = 1'b1;
               rsp_in.ok             = 1'b1;
            end
            FUNC_ACCEPT_UP: begin
               if (!up_set || (s1_req_ff.counter > up_rd_ff)) begin
                  up_we               = 1'b1;
                  up_valid_in[s1_idx] = 1'b1;
                  rsp_in.ok           = 1'b1;
               end
            end
            FUNC_RESET_DEV: begin
               up_valid_in[s1_idx]   = 1'b0;
               down_valid_in[s1_idx] = 1'b0;
               rsp_in.ok             = 1'b1;
            end
            FUNC_PEEK_UP: begin
               if (up_set) begin
                  rsp_in.ok           = 1'b1;
                  rsp_in.found        = 1'b1;
                  rsp_in.last_counter = up_rd_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         up_valid_ff   <= '0;
         down_valid_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            up_valid_ff   <= up_valid_in;
            down_valid_ff <= down_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Uplink counter store; bypass a same-cycle write to the address being read.
   always_ff @(posedge clock) begin
      if (advance && up_we) begin
         up_last_mem[s1_idx] <= s1_req_ff.counter;
      end
      if (req_accept) begin
         if (advance && up_we && (s1_idx == rd_idx)) begin
            up_rd_ff <= s1_req_ff.counter;
         end else begin
            up_rd_ff <= up_last_mem[rd_idx];
         end
      end
   end

   // Downlink counter store, same bypass.
   always_ff @(posedge clock) begin
      if (advance && down_we) begin
         down_last_mem[s1_idx] <= s1_req_ff.counter;
      end
      if (req_accept) begin
         if (advance && down_we && (s1_idx == rd_idx)) begin
            down_rd_ff <= s1_req_ff.counter;
         end else begin
            down_rd_ff <= down_last_mem[rd_idx];
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_clear_all_wipes: assert property (@(posedge clock) disable iff (reset)
      (advance && (s1_req_ff.func == FUNC_CLEAR_ALL))
      |=> ((up_valid_ff == '0) && (down_valid_ff == '0)))
      else $error("clear all left a valid bit set");

   a_accept_records: assert property (@(posedge clock) disable iff (reset)
      (advance && up_we) |=> up_valid_ff[$past(s1_idx)])
      else $error("accepted uplink transaction not recorded");

   a_peek_unset_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && (s1_req_ff.func == FUNC_PEEK_UP) && !up_set)
      |=> (!rsp_ff.found && (rsp_ff.last_counter == '0)))
      else $error("peek of unset entry returned data");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_req_ff)))
      else $error("stalled transaction lost in first stage");
`endif

endmodule

FILE: dv/per_device_replay_guard_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for per_device_replay_guard_core: random bursty requests,
// stalled responses, and an in-bench predictor of the per-device counter tables.
// Depends on pdrg_pkg and per_device_replay_guard_core.
module per_device_replay_guard_core_tb;
   import pdrg_pkg::*;

   localparam int DEV_N         = 256;
   localparam int RANDOM_ITEMS  = 450;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int TAIL_CYCLES   = 20;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_6 = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_7 = 3'd7;
   localparam logic [COUNTER_W-1:0] CTR_MAX = '1;

   typedef struct {
      req_type req;
      bit      wait_drain;
   } pending_req_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   per_device_replay_guard_core #(.DEVICE_COUNT(DEV_N)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predicted table contents.
   logic [COUNTER_W-1:0] up_ctr   [DEV_N];
   bit                   up_set   [DEV_N];
   logic [COUNTER_W-1:0] down_ctr [DEV_N];
   bit                   down_set [DEV_N];

   pending_req_type pending_q[$];
   rsp_type         verdict_q[$];

   int n_accepted = 0;
   int n_checked  = 0;
   int n_errors   = 0;
   int n_rejected = 0;
   int n_found    = 0;
   int func_seen [8];
   int cyc = 0;

   // Compute the response for one request and update the predicted tables.
   function automatic rsp_type guard_predict(req_type t);
      rsp_type r;
      int      d;
      r = '0;
      d = int'(t.device_id);
      if (t.func == FUNC_CLEAR_ALL) begin
         up_set   = '{default: 1'b0};
         down_set = '{default: 1'b0};
         r.ok = 1'b1;
      end else if (d < DEV_N) begin
         case (t.func)
            FUNC_CHECK_DOWN: begin
               r.ok = !down_set[d] || (t.counter > down_ctr[d]);
            end
            FUNC_COMMIT_DOWN: begin
               down_ctr[d] = t.counter;
               down_set[d] = 1'b1;
               r.ok = 1'b1;
            end
            FUNC_ACCEPT_UP: begin
               if (!up_set[d] || (t.counter > up_ctr[d])) begin
                  up_ctr[d] = t.counter;
                  up_set[d] = 1'b1;
                  r.ok = 1'b1;
               end
            end
            FUNC_RESET_DEV: begin
               up_set[d]   = 1'b0;
               down_set[d] = 1'b0;
               r.ok = 1'b1;
            end
            FUNC_PEEK_UP: begin
               if (up_set[d]) begin
                  r.ok = 1'b1;
                  r.found = 1'b1;
                  r.last_counter = up_ctr[d];
               end
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   task automatic queue_req(logic [FUNC_W-1:0] f, logic [DEVICE_ID_W-1:0] dev,
                            logic [COUNTER_W-1:0] ctr, bit drain);
      pending_req_type p;
      p.req.func      = f;
      p.req.device_id = dev;
      p.req.counter   = ctr;
      p.wait_drain    = drain;
      pending_q.push_back(p);
   endtask

   // Driver: bursts of requests separated by random gaps.
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_req
      pending_req_type nxt;
      rsp_type         want;
      bit              taken;
      bit              drained;
      taken = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (taken) begin
            want = guard_predict(req_payload);
            verdict_q.push_back(want);
            n_accepted <= n_accepted + 1;
            func_seen[req_payload.func]++;
            if (!want.ok) n_rejected++;
            if (want.found) n_found++;
         end
         if (!req_valid || taken) begin
            drained = !taken && (n_accepted == n_checked);
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_q.size() != 0 &&
                         (!pending_q[0].wait_drain || drained)) begin
               nxt = pending_q.pop_front();
               req_valid   <= 1'b1;
               req_payload <= nxt.req;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 16);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response side: stall on a pattern chosen by bits 9:8 of the cycle counter.
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cyc);
         $display("*** FAILED ***");
         $finish;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         case (cyc[9:8])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ~cyc[2] | cyc[0];
         endcase
      end
   end

   // Monitor: compare each response with the oldest prediction.
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_checked <= n_checked + 1;
         if (verdict_q.size() == 0) begin
            $error("response with no request outstanding: %p", rsp_payload);
            n_errors++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_payload.ok !== want.ok) begin
               $error("ok: expected %0b, got %0b", want.ok, rsp_payload.ok);
               n_errors++;
            end
            if (rsp_payload.found !== want.found) begin
               $error("found: expected %0b, got %0b", want.found, rsp_payload.found);
               n_errors++;
            end
            if (rsp_payload.last_counter !== want.last_counter) begin
               $error("last_counter: expected %h, got %h",
                      want.last_counter, rsp_payload.last_counter);
               n_errors++;
            end
         end
      end
   end

   // Stimulus and end of test.
   logic [COUNTER_W-1:0] seq_ctr [DEV_N];

   initial begin : stimulus
      logic [FUNC_W-1:0]      f;
      logic [DEVICE_ID_W-1:0] dev;
      logic [COUNTER_W-1:0]   ctr;
      int                     roll;
      int                     hot_base;
      int                     n_total;

      up_set   = '{default: 1'b0};
      down_set = '{default: 1'b0};

      // Directed: empty tables, replays, counter extremes, device extremes.
      queue_req(FUNC_PEEK_UP,     8'd0,   64'd0,   1'b0);
      queue_req(FUNC_ACCEPT_UP,   8'd0,   64'd0,   1'b0);
      queue_req(FUNC_ACCEPT_UP,   8'd0,   64'd0,   1'b0);
      queue_req(FUNC_PEEK_UP,     8'd0,   64'd0,   1'b0);
      queue_req(FUNC_ACCEPT_UP,   8'd0,   CTR_MAX, 1'b0);
      queue_req(FUNC_PEEK_UP,     8'd0,   64'd7,   1'b0);
      queue_req(FUNC_ACCEPT_UP,   8'd0,   CTR_MAX, 1'b0);
      queue_req(FUNC_CHECK_DOWN,  8'd255, 64'd0,   1'b0);
      queue_req(FUNC_COMMIT_DOWN, 8'd255, 64'd5,   1'b0);
      queue_req(FUNC_CHECK_DOWN,  8'd255, 64'd5,   1'b0);
      queue_req(FUNC_CHECK_DOWN,  8'd255, 64'd6,   1'b0);
      queue_req(FUNC_COMMIT_DOWN, 8'd255, 64'd3,   1'b0);
      queue_req(FUNC_CHECK_DOWN,  8'd255, 64'd4,   1'b0);
      queue_req(FUNC_ACCEPT_UP,   8'd255, CTR_MAX, 1'b0);
      queue_req(FUNC_RESET_DEV,   8'd255, 64'd0,   1'b0);
      queue_req(FUNC_CHECK_DOWN,  8'd255, 64'd0,   1'b0);
      queue_req(FUNC_PEEK_UP,     8'd255, 64'd0,   1'b0);
      queue_req(FUNC_UNUSED_6,    8'd0,   CTR_MAX, 1'b0);
      queue_req(FUNC_UNUSED_7,    8'd255, 64'd1,   1'b0);
      queue_req(FUNC_PEEK_UP,     8'd0,   64'd0,   1'b0);
      queue_req(FUNC_CLEAR_ALL,   8'd255, CTR_MAX, 1'b0);
      queue_req(FUNC_PEEK_UP,     8'd0,   64'd0,   1'b0);
      queue_req(FUNC_ACCEPT_UP,   8'd0,   64'd0,   1'b0);
      queue_req(FUNC_CHECK_DOWN,  8'd255, 64'd0,   1'b0);

      // Random: mostly rising counters on a few busy devices, some replays and noise.
      foreach (seq_ctr[d])
         seq_ctr[d] = ($urandom_range(0, 3) == 0) ? CTR_MAX - 64'd12 : 64'($urandom_range(0, 1000));
      hot_base = $urandom_range(0, DEV_N - 8);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 30)      f = FUNC_ACCEPT_UP;
         else if (roll < 50) f = FUNC_CHECK_DOWN;
         else if (roll < 64) f = FUNC_COMMIT_DOWN;
         else if (roll < 78) f = FUNC_PEEK_UP;
         else if (roll < 84) f = FUNC_RESET_DEV;
         else if (roll < 86) f = FUNC_CLEAR_ALL;
         else if (roll < 88) f = FUNC_UNUSED_6;
         else if (roll < 90) f = FUNC_UNUSED_7;
         else                f = FUNC_ACCEPT_UP;
         if ($urandom_range(0, 9) < 7) dev = DEVICE_ID_W'(hot_base + $urandom_range(0, 7));
         else                          dev = DEVICE_ID_W'($urandom_range(0, DEV_N - 1));
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            ctr = seq_ctr[dev] + 64'($urandom_range(1, 4));
            if (f == FUNC_ACCEPT_UP || f == FUNC_COMMIT_DOWN) seq_ctr[dev] = ctr;
         end else if (roll < 75) begin
            ctr = seq_ctr[dev] - 64'($urandom_range(0, 2));
         end else begin
            ctr = {$urandom, $urandom};
         end
         queue_req(f, dev, ctr, (i % 150) == 0);
      end
      n_total = pending_q.size();

      @(posedge clock);
      while (reset) @(posedge clock);
      // Wait until every queued transaction has been answered.
      while (n_checked < n_total)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (verdict_q.size() != 0) begin
         $error("%0d responses never arrived", verdict_q.size());
         n_errors++;
      end
      $display("ran %0d transactions: check %0d commit %0d accept %0d reset %0d",
               n_accepted, func_seen[FUNC_CHECK_DOWN], func_seen[FUNC_COMMIT_DOWN],
               func_seen[FUNC_ACCEPT_UP], func_seen[FUNC_RESET_DEV]);
      $display("clear %0d peek %0d unused %0d, %0d rejected, %0d peeks found",
               func_seen[FUNC_CLEAR_ALL], func_seen[FUNC_PEEK_UP],
               func_seen[FUNC_UNUSED_6] + func_seen[FUNC_UNUSED_7], n_rejected, n_found);
      if (n_errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

endmodule

FILE: files.f
sv/pdrg_pkg.sv
sv/per_device_replay_guard_core.sv
dv/per_device_replay_guard_core_tb.sv
